/* rtl/iel_pkg.sv */
// Package for the indexed entry list: request kinds, controller states,
// the per-cycle command that goes to every storage cell, and default sizes.
// Has no dependencies of its own.
package iel_pkg;

  localparam int DEPTH_DEF      = 256;
  localparam int LINK_WIDTH_DEF = 32;
  localparam int ITEM_WIDTH_DEF = 32;

  localparam int KIND_W  = 3;
  localparam int POS_W   = 8;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 9;

  // Number of mux levels of the read tree between two registers.
  localparam int TREE_STEP = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_ERASE  = 3'd2,
    KIND_READ   = 3'd3,
    KIND_CLEAR  = 3'd4
  } iel_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } iel_state_e;

  // Broadcast to every cell; each bit is already qualified by a committed,
  // successful request.
  typedef struct packed {
    logic append;
    logic insert;
    logic erase;
  } iel_cmd_t;

endpackage

/* rtl/iel_cell.sv */
// One storage cell of the entry list: holds a link and item pair and, on a
// command, loads the new entry or takes the entry of a neighbor cell.
// Depends on iel_pkg.
module iel_cell #(
  parameter int IDX   = 0,
  parameter int W     = 64,
  parameter int CMP_W = 9
) (
  input  logic                 clk_i,
  input  iel_pkg::iel_cmd_t    cmd_i,
  input  logic [CMP_W-1:0]     pos_i,
  input  logic [CMP_W-1:0]     cnt_i,
  input  logic [W-1:0]         new_i,
  input  logic [W-1:0]         lower_i,
  input  logic [W-1:0]         upper_i,
  output logic [W-1:0]         data_o
);

  localparam logic [CMP_W-1:0] IdxV  = CMP_W'(IDX);
  localparam logic [CMP_W-1:0] IdxV1 = CMP_W'(IDX + 1);

  logic [W-1:0] data_q;
  logic [W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.append) begin
      if (IdxV == cnt_i) begin
        data_d = new_i;
      end
    end else if (cmd_i.insert) begin
      if (IdxV == pos_i) begin
        data_d = new_i;
      end else if ((IdxV > pos_i) && (IdxV <= cnt_i)) begin
        data_d = lower_i;
      end
    end else if (cmd_i.erase) begin
      // Entries above the erased one move down by one place.
      if ((IdxV >= pos_i) && (IdxV1 < cnt_i)) begin
        data_d = upper_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* rtl/iel_rd_tree.sv */
// Read selection tree over all cells of the entry list, a binary mux tree
// with a register after every few levels.
// Depends on iel_pkg.
module iel_rd_tree #(
  parameter int DEPTH = 256,
  parameter int W     = 64,
  parameter int LVLS  = 8
) (
  input  logic             clk_i,
  input  logic [W-1:0]     ent_i [DEPTH],
  input  logic [LVLS-1:0]  sel_i,
  output logic [W-1:0]     data_o
);

  localparam int N = 1 << LVLS;

  // Heap order: node 1 is the root, leaves sit at N to 2N-1.
  logic [W-1:0] node [1:2*N-1];

  for (genvar j = 0; j < N; j++) begin : g_leaf
    if (j < DEPTH) begin : g_used
      assign node[N+j] = ent_i[j];
    end else begin : g_pad
      assign node[N+j] = '0;
    end
  end

  for (genvar k = 1; k < N; k++) begin : g_node
    localparam int H = LVLS - ($clog2(k + 1) - 1);
    logic [W-1:0] mux_c;
    assign mux_c = sel_i[H-1] ? node[2*k+1] : node[2*k];
    if ((H % iel_pkg::TREE_STEP) == 0) begin : g_reg
      logic [W-1:0] mux_q;
      always_ff @(posedge clk_i) begin
        mux_q <= mux_c;
      end
      assign node[k] = mux_q;
    end else begin : g_comb
      assign node[k] = mux_c;
    end
  end

  assign data_o = node[1];

endmodule

/* rtl/indexed_entry_list.sv */
// Indexed entry list: an ordered list of up to DEPTH link and item pairs
// held in a row of cells that all shift, hold or load in the same cycle.
// One request is in work at a time. Append, insert, erase and clear go from
// transfer to result through the request and output registers; a read also
// waits for the registered read-select tree over the cells to settle. A
// result that cannot leave because the output is stalled holds the request in
// work until the stall ends. The entry cells have no reset; only the entry
// count and the control registers are cleared, so no clearing pass follows reset.
// Depends on iel_pkg, iel_cell and iel_rd_tree.
module indexed_entry_list #(
  parameter int DEPTH      = iel_pkg::DEPTH_DEF,
  parameter int LINK_WIDTH = iel_pkg::LINK_WIDTH_DEF,
  parameter int ITEM_WIDTH = iel_pkg::ITEM_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [iel_pkg::KIND_W-1:0]    kind_i,
  input  logic [iel_pkg::POS_W-1:0]     position_i,
  input  logic [iel_pkg::WORD_W-1:0]    link_in_i,
  input  logic [iel_pkg::WORD_W-1:0]    item_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          ok_o,
  output logic [iel_pkg::WORD_W-1:0]    link_out_o,
  output logic [iel_pkg::WORD_W-1:0]    item_out_o,
  output logic [iel_pkg::COUNT_W-1:0]   entries_now_o,
  output logic                          is_empty_o
);

  localparam int W      = LINK_WIDTH + ITEM_WIDTH;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > iel_pkg::POS_W) ? CNT_W : iel_pkg::POS_W;
  localparam int LVLS   = $clog2(DEPTH);
  localparam int REGS   = LVLS / iel_pkg::TREE_STEP;
  localparam int WAIT_W = $clog2(REGS + 2);

  localparam logic [CMP_W-1:0] DepthV = CMP_W'(DEPTH);

  // Request registers, held for the whole time a request is in work.
  iel_pkg::iel_state_e    state_q, state_d;
  logic [iel_pkg::KIND_W-1:0] kind_q;
  logic [CMP_W-1:0]       pos_q;
  logic [LINK_WIDTH-1:0]  lnk_q;
  logic [ITEM_WIDTH-1:0]  itm_q;
  logic [WAIT_W-1:0]      wait_q;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  logic                   out_vld_q;
  logic                   ok_q;
  logic [LINK_WIDTH-1:0]  lnk_out_q;
  logic [ITEM_WIDTH-1:0]  itm_out_q;
  logic [CNT_W-1:0]       cnt_out_q;

  logic                   accept;
  logic                   commit;
  logic                   ok_c;
  logic                   is_read;
  logic [CMP_W-1:0]       cnt_x;
  iel_pkg::iel_cmd_t      cmd;

  logic [W-1:0]           ent [DEPTH];
  logic [W-1:0]           rd_data;

  assign accept = in_valid_i && (state_q == iel_pkg::ST_IDLE);
  assign commit = (state_q == iel_pkg::ST_BUSY) && (wait_q == '0) &&
                  (!out_vld_q || !out_stall_i);
  assign cnt_x  = CMP_W'(cnt_q);

  always_comb begin
    ok_c    = 1'b0;
    is_read = 1'b0;
    cnt_d   = cnt_q;
    case (iel_pkg::iel_kind_e'(kind_q))
      iel_pkg::KIND_APPEND: begin
        ok_c = (cnt_x != DepthV);
        if (ok_c) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      iel_pkg::KIND_INSERT: begin
        ok_c = (pos_q <= cnt_x) && (cnt_x != DepthV);
        if (ok_c) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      iel_pkg::KIND_ERASE: begin
        ok_c = (pos_q < cnt_x);
        if (ok_c) begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      iel_pkg::KIND_READ: begin
        ok_c    = (pos_q < cnt_x);
        is_read = 1'b1;
      end
      iel_pkg::KIND_CLEAR: begin
        ok_c  = 1'b1;
        cnt_d = '0;
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd.append = commit && ok_c && (kind_q == iel_pkg::KIND_APPEND);
    cmd.insert = commit && ok_c && (kind_q == iel_pkg::KIND_INSERT);
    cmd.erase  = commit && ok_c && (kind_q == iel_pkg::KIND_ERASE);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      iel_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = iel_pkg::ST_BUSY;
        end
      end
      iel_pkg::ST_BUSY: begin
        if (commit) begin
          state_d = iel_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = iel_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= iel_pkg::ST_IDLE;
      cnt_q     <= '0;
      wait_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        // The read tree needs to settle through each of its register levels.
        wait_q <= (kind_i == iel_pkg::KIND_READ) ? WAIT_W'(REGS) : '0;
      end else if (wait_q != '0) begin
        wait_q <= wait_q - 1'b1;
      end
      if (commit) begin
        cnt_q     <= cnt_d;
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      pos_q  <= CMP_W'(position_i);
      lnk_q  <= LINK_WIDTH'(link_in_i);
      itm_q  <= ITEM_WIDTH'(item_in_i);
    end
    if (commit) begin
      ok_q      <= ok_c;
      cnt_out_q <= cnt_d;
      if (is_read && ok_c) begin
        lnk_out_q <= rd_data[W-1:ITEM_WIDTH];
        itm_out_q <= rd_data[ITEM_WIDTH-1:0];
      end else begin
        lnk_out_q <= '0;
        itm_out_q <= '0;
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] lower;
    logic [W-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = ent[i+1];
    end
    iel_cell #(
      .IDX   (i),
      .W     (W),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (pos_q),
      .cnt_i   (cnt_x),
      .new_i   ({lnk_q, itm_q}),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (ent[i])
    );
  end

  iel_rd_tree #(
    .DEPTH (DEPTH),
    .W     (W),
    .LVLS  (LVLS)
  ) u_rd_tree (
    .clk_i  (clk_i),
    .ent_i  (ent),
    .sel_i  (pos_q[LVLS-1:0]),
    .data_o (rd_data)
  );

  assign in_stall_o    = (state_q != iel_pkg::ST_IDLE);
  assign out_valid_o   = out_vld_q;
  assign ok_o          = ok_q;
  assign link_out_o    = iel_pkg::WORD_W'(lnk_out_q);
  assign item_out_o    = iel_pkg::WORD_W'(itm_out_q);
  assign entries_now_o = iel_pkg::COUNT_W'(cnt_out_q);
  assign is_empty_o    = (cnt_out_q == '0);

  // The entry count never goes past the capacity.
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(cnt_q) <= DepthV)
    else $error("entry count above capacity");

  // At most one kind of cell update is broadcast in a cycle.
  a_cmd_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.append, cmd.insert, cmd.erase}))
    else $error("more than one cell update at once");

  // A successful append grows the list by exactly one entry.
  a_append_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.append |=> (cnt_q == CNT_W'($past(cnt_q) + 1'b1)))
    else $error("append did not grow the count by one");

  // The read settle counter only runs while a request is in work.
  a_wait_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wait_q != '0) |-> (state_q == iel_pkg::ST_BUSY))
    else $error("read wait counter running while idle");

endmodule
